### sv/mspt_pkg.sv
// shared types and constants for the multi-slot periodic timer
// no dependencies; imported by every module of the block
package mspt_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W     = $clog2(SLOTS + 1);
    localparam int TIME_W   = 32;
    localparam int FIRED_W  = 16;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [TIME_W-1:0] interval_ms;
        logic              single_shot;
        logic [4:0]        timer_id;
    } req_t;

    typedef struct packed {
        logic [4:0]         new_id;
        logic               table_full;
        logic [FIRED_W-1:0] fired_mask;
    } rsp_t;

    // status from the shared slot unit back to the sequencer
    typedef struct packed {
        logic fire;
        logic keep;
    } step_t;

endpackage

### sv/mspt_step_unit.sv
// shared slot unit: advances one slot's elapsed count and tests it against its period
// depends on mspt_pkg
module mspt_step_unit
    import mspt_pkg::*;
(
    input  logic              active,
    input  logic              single,
    input  logic [TIME_W-1:0] elapsed,
    input  logic [TIME_W-1:0] period,
    output logic [TIME_W-1:0] elapsed_new,
    output step_t             status
);

    logic [TIME_W-1:0] bumped;
    logic              hit;

    assign bumped = elapsed + TIME_W'(1);
    assign hit    = active && (bumped == period);

    always_comb
    begin
        status.fire = hit;
        // a single-shot slot is freed on its firing
        status.keep = active && !(hit && single);
        elapsed_new = hit ? '0 : bumped;
    end

endmodule

### sv/multi_slot_periodic_timer.sv
// top level of the multi-slot periodic timer: command sequencer and slot storage
// depends on mspt_pkg and mspt_step_unit
//
// usage:
//   a command transfer happens on a rising edge with start high and busy low;
//   request carries command, interval_ms, single_shot and timer_id
//   every command yields exactly one result on the result port, marked by
//   done for one cycle; the receiver has no way to hold it off
//   start and stop commands give their result the cycle after the transfer
//   and busy stays low, so commands may follow back to back
//   a tick walks the slot table through the shared increment/compare unit,
//   one slot per cycle, holding busy for the whole walk; its result appears
//   when the last slot has been stepped, and busy drops in that same cycle
//   the tick walks slot by slot since there is one shared unit and a single table write port
//   reset clears all active and single-shot flags and the sequencer; period
//   and elapsed storage is left as is and is only read for active slots
module multi_slot_periodic_timer
    import mspt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    logic [SLOTS-1:0]  active_reg, active_next;
    logic [SLOTS-1:0]  single_reg, single_next;
    logic [TIME_W-1:0] period_reg  [SLOTS];
    logic [TIME_W-1:0] elapsed_reg [SLOTS];

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [FIRED_W-1:0] mask_reg, mask_next;
    rsp_t               result_reg, result_next;

    logic [ID_W-1:0]   top_id;
    logic              accept;
    logic              last;
    logic              stop_ok;
    logic              start_ok;
    logic [IDX_W-1:0]  start_idx;
    logic [IDX_W-1:0]  stop_idx;
    logic [TIME_W-1:0] elapsed_new;
    step_t             status;

    assign accept = start && !busy_reg;
    assign last   = (idx_reg == IDX_W'(SLOTS - 1));

    // highest active id, zero when the table is empty
    always_comb
    begin
        top_id = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (active_reg[k])
            begin
                top_id = ID_W'(k + 1);
            end
        end
    end

    assign start_idx = IDX_W'(top_id);
    assign start_ok  = (request.interval_ms != '0) && (32'(top_id) < SLOTS);
    assign stop_idx  = IDX_W'(request.timer_id - 5'd1);
    assign stop_ok   = (request.timer_id != 5'd0) && (32'(request.timer_id) <= SLOTS);

    mspt_step_unit u_step (
        .active      (active_reg[idx_reg]),
        .single      (single_reg[idx_reg]),
        .elapsed     (elapsed_reg[idx_reg]),
        .period      (period_reg[idx_reg]),
        .elapsed_new (elapsed_new),
        .status      (status)
    );

    always_comb
    begin
        active_next = active_reg;
        single_next = single_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        result_next = result_reg;

        if (busy_reg)
        begin
            active_next[idx_reg] = status.keep;
            if (status.fire && (32'(idx_reg) < FIRED_W))
            begin
                mask_next = mask_reg | (FIRED_W'(1) << idx_reg);
            end
            idx_next = idx_reg + IDX_W'(1);
            if (last)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                idx_next    = '0;
                result_next = '{new_id: 5'd0, table_full: 1'b0, fired_mask: mask_next};
            end
        end
        else if (accept)
        begin
            done_next   = 1'b1;
            result_next = '0;
            unique case (request.command)
                CMD_TICK:
                begin
                    busy_next = 1'b1;
                    done_next = 1'b0;
                    idx_next  = '0;
                    mask_next = '0;
                end
                CMD_START:
                begin
                    if (request.interval_ms != '0)
                    begin
                        if (start_ok)
                        begin
                            active_next[start_idx] = 1'b1;
                            single_next[start_idx] = request.single_shot;
                            result_next.new_id     = 5'(top_id + ID_W'(1));
                        end
                        else
                        begin
                            result_next.table_full = 1'b1;
                        end
                    end
                end
                CMD_STOP:
                begin
                    if (stop_ok)
                    begin
                        active_next[stop_idx] = 1'b0;
                    end
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            single_reg <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            single_reg <= single_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
        end
    end

    // payload and slot storage, single write port
    always_ff @(posedge clk)
    begin
        mask_reg   <= mask_next;
        result_reg <= result_next;
        if (busy_reg)
        begin
            if (active_reg[idx_reg])
            begin
                elapsed_reg[idx_reg] <= elapsed_new;
            end
        end
        else if (accept && (request.command == CMD_START) && start_ok)
        begin
            period_reg[start_idx]  <= request.interval_ms;
            elapsed_reg[start_idx] <= '0;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### test/tb_multi_slot_periodic_timer.sv
`timescale 1ns / 1ps
// self-checking testbench for multi_slot_periodic_timer: directed table, then random commands
// depends on mspt_pkg and the multi_slot_periodic_timer rtl; every result checked in order
module tb_multi_slot_periodic_timer;
    import mspt_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1650;
    localparam int         LIMIT_CYCLES = 400000;

    typedef struct {
        req_t rq;
        int   reps;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    // typed expectation travels with the request it belongs to
    bit   row_typed = 1'b0;
    rsp_t row_want = '0;

    // timer table as the block should hold it
    logic        tmr_active[SLOTS];
    logic        tmr_one_shot[SLOTS];
    logic [31:0] tmr_period[SLOTS];
    logic [31:0] tmr_elapsed[SLOTS];

    rsp_t      expected_results[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        result_count = 0;
    int        cycle_count = 0;

    multi_slot_periodic_timer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // applies one command to the table and returns the result it should give
    function automatic rsp_t predict_timer_result(input req_t rq);
        rsp_t r;
        int   top;
        r   = '0;
        top = 0;
        case (rq.command)
            CMD_TICK:
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (tmr_active[k])
                    begin
                        tmr_elapsed[k] = tmr_elapsed[k] + 32'd1;
                        if (tmr_elapsed[k] == tmr_period[k])
                        begin
                            if (k < FIRED_W)
                                r.fired_mask[k] = 1'b1;
                            if (tmr_one_shot[k])
                                tmr_active[k] = 1'b0;
                            else
                                tmr_elapsed[k] = '0;
                        end
                    end
                end
            end
            CMD_START:
            begin
                if (rq.interval_ms != '0)
                begin
                    for (int k = 0; k < SLOTS; k++)
                        if (tmr_active[k])
                            top = k + 1;
                    if (top + 1 > SLOTS)
                        r.table_full = 1'b1;
                    else
                    begin
                        tmr_active[top]   = 1'b1;
                        tmr_one_shot[top] = rq.single_shot;
                        tmr_period[top]   = rq.interval_ms;
                        tmr_elapsed[top]  = '0;
                        r.new_id          = 5'(top + 1);
                    end
                end
            end
            CMD_STOP:
            begin
                if (rq.timer_id != 5'd0 && rq.timer_id <= SLOTS)
                    tmr_active[rq.timer_id - 5'd1] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // check results first, then record the transfer taken at this edge
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        rsp_t got;
        if (rst_n)
        begin
            if (done)
            begin
                result_count++;
                if (expected_results.size() == 0)
                    note_failure($sformatf("unexpected result %0d: new_id %0d full %0d fired %h",
                        result_count, result.new_id, result.table_full, result.fired_mask));
                else
                begin
                    want = expected_results.pop_front();
                    if (result.new_id !== want.new_id || result.table_full !== want.table_full
                        || result.fired_mask !== want.fired_mask)
                        note_failure($sformatf(
                            "mismatch on result %0d: new_id %0d/%0d full %0d/%0d fired %h/%h",
                            result_count, want.new_id, result.new_id, want.table_full,
                            result.table_full, want.fired_mask, result.fired_mask));
                end
            end
            if (start && !busy)
            begin
                got = predict_timer_result(request);
                expected_results.insert(expected_results.size(), row_typed ? row_want : got);
            end
        end
    end

    task automatic add_row(input logic [1:0] cmd, input logic [31:0] ivl, input logic one_shot,
                           input logic [4:0] id, input int reps, input bit typed,
                           input logic [4:0] want_id, input logic want_full,
                           input logic [15:0] want_fired);
        stim_row_t row;
        row.rq.command     = cmd;
        row.rq.interval_ms = ivl;
        row.rq.single_shot = one_shot;
        row.rq.timer_id    = id;
        row.reps           = reps;
        row.typed          = typed;
        row.want.new_id     = want_id;
        row.want.table_full = want_full;
        row.want.fired_mask = want_fired;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_command(input req_t rq, input bit typed, input rsp_t want,
                                input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        request   <= rq;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        req_t rq;
        int   counted;
        int   phase;
        int   last_phase;
        int   idle_pct;
        int   r;
        int   pick;
        int   n_active;
        counted    = 0;
        last_phase = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            tmr_active[k]   = 1'b0;
            tmr_one_shot[k] = 1'b0;
        end

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // command, interval, single, id, repeats, typed, new_id, full, fired
        add_row(CMD_TICK,   32'd0,          1'b0, 5'd0,  1,  1, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_STOP,   32'd0,          1'b0, 5'd0,  1,  1, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_STOP,   32'hFFFF_FFFF,  1'b1, 5'd31, 1,  1, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF,  1'b1, 5'd31, 1,  1, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_START,  32'd0,          1'b1, 5'd0,  1,  1, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_START,  32'd1,          1'b0, 5'd0,  1,  1, 5'd1, 1'b0, 16'h0000);
        add_row(CMD_START,  32'hFFFF_FFFF,  1'b1, 5'd0,  1,  0, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_START,  32'd2,          1'b1, 5'd0,  1,  0, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_START,  32'd3,          1'b0, 5'd0,  13, 0, 5'd0, 1'b0, 16'h0000);
        // every slot taken: start refused
        add_row(CMD_START,  32'd7,          1'b0, 5'd0,  1,  1, 5'd0, 1'b1, 16'h0000);
        add_row(CMD_TICK,   32'd0,          1'b0, 5'd0,  2,  0, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_STOP,   32'd0,          1'b0, 5'd16, 1,  0, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_STOP,   32'd0,          1'b0, 5'd17, 1,  1, 5'd0, 1'b0, 16'h0000);
        // single-shot slot 3 already freed by its firing
        add_row(CMD_STOP,   32'd0,          1'b0, 5'd3,  1,  0, 5'd0, 1'b0, 16'h0000);
        add_row(CMD_START,  32'd5,          1'b0, 5'd0,  1,  0, 5'd0, 1'b0, 16'h0000);

        foreach (directed_rows[i])
            repeat (directed_rows[i].reps)
                send_command(directed_rows[i].rq, directed_rows[i].typed,
                             directed_rows[i].want, 0);
        drain_results();

        while (counted < RANDOM_ITEMS)
        begin
            phase = counted * 4 / RANDOM_ITEMS;
            if (phase != last_phase)
            begin
                drain_results();
                last_phase = phase;
            end
            case (phase)
                1:       idle_pct = 50;
                3:       idle_pct = 36;
                default: idle_pct = 0;
            endcase

            rq.interval_ms = $urandom;
            rq.single_shot = 1'($urandom_range(1));
            rq.timer_id    = 5'($urandom_range(31));
            r = $urandom_range(99);
            if (r < 45)
                rq.command = CMD_TICK;
            else if (r < 75)
            begin
                rq.command = CMD_START;
                r = $urandom_range(99);
                if (r < 70)
                    rq.interval_ms = $urandom_range(6, 1);
                else if (r < 85)
                    rq.interval_ms = $urandom_range(40, 7);
                else if (r >= 95)
                    rq.interval_ms = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            end
            else if (r < 97)
            begin
                rq.command = CMD_STOP;
                n_active = 0;
                for (int k = 0; k < SLOTS; k++)
                    if (tmr_active[k])
                        n_active++;
                // mostly stop a live timer, otherwise any id
                if (n_active > 0 && $urandom_range(99) < 65)
                begin
                    pick = $urandom_range(n_active - 1);
                    for (int k = 0; k < SLOTS; k++)
                        if (tmr_active[k])
                        begin
                            if (pick == 0)
                                rq.timer_id = 5'(k + 1);
                            pick--;
                        end
                end
            end
            else
                rq.command = CMD_UNUSED;

            send_command(rq, 1'b0, '0, idle_pct);
            if (rq.command != CMD_UNUSED)
                counted++;
        end

        drain_results();
        repeat (2 * SLOTS + 4) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
